// File: rtl/integer_to_ascii_formatter_unit_macros.svh
// Assertion macros for the checker file of the formatter.
// Each macro takes a label, the clock, the active-low reset, an
// antecedent and a consequent.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITOA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter assertion failed");

`endif

// File: rtl/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    // Request selector codes.
    localparam logic [3:0] FUNC_LIT   = 4'd0;
    localparam logic [3:0] FUNC_I16   = 4'd1;
    localparam logic [3:0] FUNC_U16   = 4'd2;
    localparam logic [3:0] FUNC_I32   = 4'd3;
    localparam logic [3:0] FUNC_U32   = 4'd4;
    localparam logic [3:0] FUNC_HEX16 = 4'd5;
    localparam logic [3:0] FUNC_HEX8  = 4'd6;
    localparam logic [3:0] FUNC_BIN16 = 4'd7;
    localparam logic [3:0] FUNC_BIN8  = 4'd8;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_HEX_A = 8'h37; // 'A' minus ten

    // Power-of-ten positions: 0 is 10^9, 9 is 10^0.
    localparam logic [3:0] POS_START32 = 4'd0;
    localparam logic [3:0] POS_START16 = 4'd5;
    localparam logic [3:0] POS_LAST    = 4'd9;

    // Digit counts minus one for the shift-out modes.
    localparam logic [3:0] CNT_HEX16 = 4'd3;
    localparam logic [3:0] CNT_HEX8  = 4'd1;
    localparam logic [3:0] CNT_BIN16 = 4'd15;
    localparam logic [3:0] CNT_BIN8  = 4'd7;

    // Datapath actions, one per microcode step.
    typedef enum logic [3:0] {
        ACT_IDLE,
        ACT_LIT,
        ACT_NEG16,
        ACT_LD16,
        ACT_NEG32,
        ACT_LD32,
        ACT_ZCHK,
        ACT_SKIP,
        ACT_SUB,
        ACT_DIG,
        ACT_HSET16,
        ACT_HSET8,
        ACT_HEX,
        ACT_BSET16,
        ACT_BSET8,
        ACT_BIN
    } t_act;

    typedef logic [3:0] t_upc;

    // Microcode addresses.
    localparam t_upc UPC_IDLE   = 4'd0;
    localparam t_upc UPC_LIT    = 4'd1;
    localparam t_upc UPC_NEG16  = 4'd2;
    localparam t_upc UPC_LD16   = 4'd3;
    localparam t_upc UPC_NEG32  = 4'd4;
    localparam t_upc UPC_LD32   = 4'd5;
    localparam t_upc UPC_ZCHK   = 4'd6;
    localparam t_upc UPC_SKIP   = 4'd7;
    localparam t_upc UPC_SUB    = 4'd8;
    localparam t_upc UPC_DIG    = 4'd9;
    localparam t_upc UPC_HSET16 = 4'd10;
    localparam t_upc UPC_HEX    = 4'd11;
    localparam t_upc UPC_HSET8  = 4'd12;
    localparam t_upc UPC_BSET16 = 4'd13;
    localparam t_upc UPC_BIN    = 4'd14;
    localparam t_upc UPC_BSET8  = 4'd15;

    // One control word: the action, and where to go when the datapath
    // flag is set or clear.
    typedef struct packed {
        t_act act;
        t_upc tgt_t;
        t_upc tgt_f;
    } t_uword;

    // Sequencer to datapath.
    typedef struct packed {
        t_act act;
        logic load;
    } t_ctl;

    // Datapath to sequencer.
    typedef struct packed {
        logic flag;
        logic hold;
    } t_sts;

    function automatic t_uword uc_rom(input t_upc pc);
        t_uword w;
        unique case (pc)
            UPC_IDLE:   w = '{ACT_IDLE,   UPC_IDLE, UPC_IDLE};
            UPC_LIT:    w = '{ACT_LIT,    UPC_IDLE, UPC_IDLE};
            UPC_NEG16:  w = '{ACT_NEG16,  UPC_ZCHK, UPC_ZCHK};
            UPC_LD16:   w = '{ACT_LD16,   UPC_ZCHK, UPC_ZCHK};
            UPC_NEG32:  w = '{ACT_NEG32,  UPC_ZCHK, UPC_ZCHK};
            UPC_LD32:   w = '{ACT_LD32,   UPC_ZCHK, UPC_ZCHK};
            UPC_ZCHK:   w = '{ACT_ZCHK,   UPC_IDLE, UPC_SKIP};
            UPC_SKIP:   w = '{ACT_SKIP,   UPC_SKIP, UPC_SUB};
            UPC_SUB:    w = '{ACT_SUB,    UPC_SUB,  UPC_DIG};
            UPC_DIG:    w = '{ACT_DIG,    UPC_IDLE, UPC_SUB};
            UPC_HSET16: w = '{ACT_HSET16, UPC_HEX,  UPC_HEX};
            UPC_HEX:    w = '{ACT_HEX,    UPC_IDLE, UPC_HEX};
            UPC_HSET8:  w = '{ACT_HSET8,  UPC_HEX,  UPC_HEX};
            UPC_BSET16: w = '{ACT_BSET16, UPC_BIN,  UPC_BIN};
            UPC_BIN:    w = '{ACT_BIN,    UPC_IDLE, UPC_BIN};
            UPC_BSET8:  w = '{ACT_BSET8,  UPC_BIN,  UPC_BIN};
        endcase
        return w;
    endfunction

    // Entry point of each request; unused selectors stay idle.
    function automatic t_upc uc_entry(input logic [3:0] func);
        t_upc pc;
        unique case (func)
            FUNC_LIT:   pc = UPC_LIT;
            FUNC_I16:   pc = UPC_NEG16;
            FUNC_U16:   pc = UPC_LD16;
            FUNC_I32:   pc = UPC_NEG32;
            FUNC_U32:   pc = UPC_LD32;
            FUNC_HEX16: pc = UPC_HSET16;
            FUNC_HEX8:  pc = UPC_HSET8;
            FUNC_BIN16: pc = UPC_BSET16;
            FUNC_BIN8:  pc = UPC_BSET8;
            default:    pc = UPC_IDLE;
        endcase
        return pc;
    endfunction

    function automatic logic [31:0] pow10(input logic [3:0] pos);
        logic [31:0] p;
        unique case (pos)
            4'd0:    p = 32'd1000000000;
            4'd1:    p = 32'd100000000;
            4'd2:    p = 32'd10000000;
            4'd3:    p = 32'd1000000;
            4'd4:    p = 32'd100000;
            4'd5:    p = 32'd10000;
            4'd6:    p = 32'd1000;
            4'd7:    p = 32'd100;
            4'd8:    p = 32'd10;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CHAR_ZERO + {4'd0, nib};
        end else begin
            c = CHAR_HEX_A + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/itoa_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module itoa_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [3:0]      i_in_func,
    input  wire itoa_pkg::t_sts  i_sts,
    output itoa_pkg::t_ctl       o_ctl,
    output logic                 o_in_stall
);

    itoa_pkg::t_upc   r_pc;
    itoa_pkg::t_upc   n_pc;
    itoa_pkg::t_uword w_word;
    logic             w_accept;

    assign w_word     = itoa_pkg::uc_rom(r_pc);
    assign o_in_stall = (w_word.act != itoa_pkg::ACT_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_ctl.act  = w_word.act;
    assign o_ctl.load = w_accept;

    // The step holds while the datapath waits on the output register.
    always_comb begin
        priority if (i_sts.hold) begin
            n_pc = r_pc;
        end else if (w_word.act == itoa_pkg::ACT_IDLE) begin
            n_pc = w_accept ? itoa_pkg::uc_entry(i_in_func) : r_pc;
        end else begin
            n_pc = i_sts.flag ? w_word.tgt_t : w_word.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= itoa_pkg::UPC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/itoa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module itoa_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire itoa_pkg::t_ctl  i_ctl,
    input  wire logic [31:0]     i_in_value,
    input  wire logic            i_out_stall,
    output itoa_pkg::t_sts       o_sts,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_ascii_char,
    output logic                 o_out_last
);

    logic [31:0] r_val;
    logic [31:0] n_val;
    logic [3:0]  r_pos;
    logic [3:0]  n_pos;
    logic [3:0]  r_dig;
    logic [3:0]  n_dig;
    logic        r_ovalid;
    logic [7:0]  r_char;
    logic        r_last;

    logic [31:0] w_pow;
    logic [32:0] w_diff;
    logic        w_ge;
    logic [16:0] w_mag16;
    logic        w_emit;
    logic [7:0]  w_char;
    logic        w_last;
    logic        w_flag;
    logic        w_hold;

    assign w_pow   = itoa_pkg::pow10(r_pos);
    assign w_diff  = {1'b0, r_val} - {1'b0, w_pow};
    assign w_ge    = !w_diff[32];
    assign w_mag16 = 17'h10000 - {1'b0, r_val[15:0]};

    always_comb begin
        n_val  = r_val;
        n_pos  = r_pos;
        n_dig  = r_dig;
        w_emit = 1'b0;
        w_char = itoa_pkg::CHAR_ZERO;
        w_last = 1'b0;
        w_flag = 1'b0;
        unique case (i_ctl.act)
            itoa_pkg::ACT_IDLE: begin
                if (i_ctl.load) begin
                    n_val = i_in_value;
                end
            end
            itoa_pkg::ACT_LIT: begin
                w_emit = 1'b1;
                w_char = r_val[7:0];
                w_last = 1'b1;
            end
            itoa_pkg::ACT_NEG16: begin
                w_emit = r_val[15];
                w_char = itoa_pkg::CHAR_MINUS;
                n_val  = r_val[15] ? {15'd0, w_mag16} : {16'd0, r_val[15:0]};
                n_pos  = itoa_pkg::POS_START16;
            end
            itoa_pkg::ACT_LD16: begin
                n_val = {16'd0, r_val[15:0]};
                n_pos = itoa_pkg::POS_START16;
            end
            itoa_pkg::ACT_NEG32: begin
                w_emit = r_val[31];
                w_char = itoa_pkg::CHAR_MINUS;
                n_val  = r_val[31] ? (~r_val + 32'd1) : r_val;
                n_pos  = itoa_pkg::POS_START32;
            end
            itoa_pkg::ACT_LD32: begin
                n_pos = itoa_pkg::POS_START32;
            end
            itoa_pkg::ACT_ZCHK: begin
                w_flag = (r_val == 32'd0);
                w_emit = w_flag;
                w_last = 1'b1;
            end
            itoa_pkg::ACT_SKIP: begin
                w_flag = (r_pos < itoa_pkg::POS_LAST) && !w_ge;
                n_dig  = 4'd0;
                if (w_flag) begin
                    n_pos = r_pos + 4'd1;
                end
            end
            itoa_pkg::ACT_SUB: begin
                w_flag = w_ge;
                if (w_ge) begin
                    n_val = w_diff[31:0];
                    n_dig = r_dig + 4'd1;
                end
            end
            itoa_pkg::ACT_DIG: begin
                w_flag = (r_pos == itoa_pkg::POS_LAST);
                w_emit = 1'b1;
                w_char = itoa_pkg::CHAR_ZERO + {4'd0, r_dig};
                w_last = w_flag;
                n_dig  = 4'd0;
                n_pos  = r_pos + 4'd1;
            end
            itoa_pkg::ACT_HSET16: begin
                n_val = {r_val[15:0], 16'd0};
                n_pos = itoa_pkg::CNT_HEX16;
            end
            itoa_pkg::ACT_HSET8: begin
                n_val = {r_val[7:0], 24'd0};
                n_pos = itoa_pkg::CNT_HEX8;
            end
            itoa_pkg::ACT_HEX: begin
                w_flag = (r_pos == 4'd0);
                w_emit = 1'b1;
                w_char = itoa_pkg::hex_char(r_val[31:28]);
                w_last = w_flag;
                n_val  = {r_val[27:0], 4'd0};
                n_pos  = r_pos - 4'd1;
            end
            itoa_pkg::ACT_BSET16: begin
                n_val = {r_val[15:0], 16'd0};
                n_pos = itoa_pkg::CNT_BIN16;
            end
            itoa_pkg::ACT_BSET8: begin
                n_val = {r_val[7:0], 24'd0};
                n_pos = itoa_pkg::CNT_BIN8;
            end
            itoa_pkg::ACT_BIN: begin
                w_flag = (r_pos == 4'd0);
                w_emit = 1'b1;
                w_char = r_val[31] ? itoa_pkg::CHAR_ONE : itoa_pkg::CHAR_ZERO;
                w_last = w_flag;
                n_val  = {r_val[30:0], 1'b0};
                n_pos  = r_pos - 4'd1;
            end
        endcase
    end

    // A step that emits waits while the output register is full and stalled.
    assign w_hold     = w_emit && r_ovalid && i_out_stall;
    assign o_sts.flag = w_flag;
    assign o_sts.hold = w_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val    <= 32'd0;
            r_pos    <= 4'd0;
            r_dig    <= 4'd0;
            r_ovalid <= 1'b0;
        end else if (!w_hold) begin
            r_val <= n_val;
            r_pos <= n_pos;
            r_dig <= n_dig;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && !w_hold) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_out_ascii_char = r_char;
    assign o_out_last       = r_last;

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Beat payload
// request   in         i_in_valid / o_in_stall    i_in_func, i_in_value
// character out        o_out_valid / i_out_stall  o_out_ascii_char, o_out_last
//
// A request is taken while the block is idle, then one microcode step per cycle unless a stall holds it.
// Hex and binary: one setup step, then one character per cycle unless the output stalls.
// Decimal: a load or sign step, a zero check, one step per skipped power of
// ten plus one, and for each printed digit d, d + 2 steps; the subtract loop
// sets this figure.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register. A stall on the character channel holds the emitting
// step; the next character waits until the output register is free.

module integer_to_ascii_formatter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_in_func,
    input  wire logic [31:0] i_in_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_ascii_char,
    output logic             o_out_last
);

    // The sequencer steps through the control program, and the datapath
    // holds the remaining value, the power-of-ten position (or the count of
    // digits left, less one, in the shift modes), the digit being counted, and the
    // output register that separates the work from the character channel.
    itoa_pkg::t_ctl w_ctl;
    itoa_pkg::t_sts w_sts;

    itoa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_func),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_in_stall (o_in_stall)
    );

    itoa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_in_value       (i_in_value),
        .i_out_stall      (i_out_stall),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_out_ascii_char (o_out_ascii_char),
        .o_out_last       (o_out_last)
    );

endmodule

`default_nettype wire

// File: rtl/itoa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_formatter_unit_macros.svh"

module itoa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [3:0]  i_in_func,
    input wire logic [31:0] i_in_value,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_out_ascii_char,
    input wire logic        o_out_last
);

    // A stalled character beat holds.
    `ITOA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_ascii_char) && $stable(o_out_last))

    // An unused selector is dropped and leaves the block idle.
    `ITOA_ASSERT_NEXT(a_bad_func_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_func > itoa_pkg::FUNC_BIN8), !o_in_stall)

    // A valid request keeps the block busy in the following cycle.
    `ITOA_ASSERT_NEXT(a_good_func_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_func <= itoa_pkg::FUNC_BIN8), o_in_stall)

    // Returning to idle means the final character sits in the output register.
    `ITOA_ASSERT_NOW(a_done_last, i_clk, i_rst_n, $fell(o_in_stall), o_out_valid && o_out_last)

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_in_func        (i_in_func),
    .i_in_value       (i_in_value),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_ascii_char (o_out_ascii_char),
    .o_out_last       (o_out_last)
);

`default_nettype wire
